// File: rtl/lpfp_pkg.sv
`timescale 1ns / 1ps

package lpfp_pkg;

  // Parser phases
  localparam logic [1:0] PhPrefix = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhName   = 2'd2;
  localparam logic [1:0] PhText   = 2'd3;

  // Result status codes
  localparam logic [2:0] StHdr      = 3'd0;
  localparam logic [2:0] StName     = 3'd1;
  localparam logic [2:0] StText     = 3'd2;
  localparam logic [2:0] StRange    = 3'd3;
  localparam logic [2:0] StMismatch = 3'd4;

  // Frame layout
  localparam logic [31:0] HeaderBytes    = 32'd12;
  localparam logic [3:0]  PrefixLastIdx  = 4'd3;
  localparam logic [3:0]  TypeEndIdx     = 4'd4;
  localparam logic [3:0]  NameEndIdx     = 4'd8;
  localparam logic [3:0]  HeaderLastIdx  = 4'd11;
  localparam logic [31:0] DefaultMaxBody = 32'd32 << 20;

  // One result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic [31:0] message_type;
  } result_t;

endpackage

// File: rtl/lpfp_parse.sv
`timescale 1ns / 1ps

module lpfp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         data_byte_i,
  input  logic [31:0]        max_body_len_i,
  output lpfp_pkg::result_t  result_o
);

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  header_index_q, header_index_d;
  logic [31:0] body_length_q, body_length_d;
  logic [31:0] type_word_q, type_word_d;
  logic [31:0] name_length_q, name_length_d;
  logic [31:0] text_length_q, text_length_d;
  logic [31:0] bytes_left_q, bytes_left_d;

  logic [31:0] body_shift;
  logic [31:0] left_dec;
  logic [33:0] header_sum;
  logic        restart;

  assign body_shift = {body_length_q[23:0], data_byte_i};
  assign left_dec   = bytes_left_q - 32'd1;
  // Wide sum of header and both lengths, without wrap
  assign header_sum = 34'(lpfp_pkg::HeaderBytes) + 34'(name_length_q)
                    + 34'({text_length_q[23:0], data_byte_i});

  // Decode one byte against the current phase
  always_comb begin
    phase_d        = phase_q;
    header_index_d = header_index_q;
    body_length_d  = body_length_q;
    type_word_d    = type_word_q;
    name_length_d  = name_length_q;
    text_length_d  = text_length_q;
    bytes_left_d   = bytes_left_q;
    restart        = 1'b0;
    result_o       = '{status: lpfp_pkg::StHdr, payload_byte: 8'd0,
                       frame_end: 1'b0, message_type: 32'd0};

    unique case (phase_q)
      lpfp_pkg::PhPrefix: begin
        body_length_d = body_shift;
        if (header_index_q >= lpfp_pkg::PrefixLastIdx) begin
          if (body_shift < lpfp_pkg::HeaderBytes || body_shift > max_body_len_i) begin
            result_o.status = lpfp_pkg::StRange;
            restart         = 1'b1;
          end else begin
            phase_d        = lpfp_pkg::PhHeader;
            header_index_d = 4'd0;
          end
        end else begin
          header_index_d = header_index_q + 4'd1;
        end
      end
      lpfp_pkg::PhHeader: begin
        if (header_index_q < lpfp_pkg::TypeEndIdx) begin
          type_word_d = {type_word_q[23:0], data_byte_i};
        end else if (header_index_q < lpfp_pkg::NameEndIdx) begin
          name_length_d = {name_length_q[23:0], data_byte_i};
        end else begin
          text_length_d = {text_length_q[23:0], data_byte_i};
        end
        if (header_index_q >= lpfp_pkg::HeaderLastIdx) begin
          // Only the text length can still change on the last header byte
          if (header_sum != {2'b00, body_length_q}) begin
            result_o.status = lpfp_pkg::StMismatch;
            restart         = 1'b1;
          end else if (name_length_q != 32'd0) begin
            phase_d      = lpfp_pkg::PhName;
            bytes_left_d = name_length_q;
          end else if (text_length_d != 32'd0) begin
            phase_d      = lpfp_pkg::PhText;
            bytes_left_d = text_length_d;
          end else begin
            result_o.frame_end    = 1'b1;
            result_o.message_type = type_word_q;
            restart               = 1'b1;
          end
        end else begin
          header_index_d = header_index_q + 4'd1;
        end
      end
      lpfp_pkg::PhName: begin
        result_o.status       = lpfp_pkg::StName;
        result_o.payload_byte = data_byte_i;
        bytes_left_d          = left_dec;
        if (left_dec == 32'd0) begin
          if (text_length_q != 32'd0) begin
            phase_d      = lpfp_pkg::PhText;
            bytes_left_d = text_length_q;
          end else begin
            result_o.frame_end    = 1'b1;
            result_o.message_type = type_word_q;
            restart               = 1'b1;
          end
        end
      end
      default: begin
        result_o.status       = lpfp_pkg::StText;
        result_o.payload_byte = data_byte_i;
        bytes_left_d          = left_dec;
        if (left_dec == 32'd0) begin
          result_o.frame_end    = 1'b1;
          result_o.message_type = type_word_q;
          restart               = 1'b1;
        end
      end
    endcase

    // Drop all frame state after an error or a finished frame
    if (restart) begin
      phase_d        = lpfp_pkg::PhPrefix;
      header_index_d = 4'd0;
      body_length_d  = 32'd0;
      type_word_d    = 32'd0;
      name_length_d  = 32'd0;
      text_length_d  = 32'd0;
      bytes_left_d   = 32'd0;
    end
  end

  // Advance frame state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= lpfp_pkg::PhPrefix;
      header_index_q <= 4'd0;
      body_length_q  <= 32'd0;
      type_word_q    <= 32'd0;
      name_length_q  <= 32'd0;
      text_length_q  <= 32'd0;
      bytes_left_q   <= 32'd0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      header_index_q <= header_index_d;
      body_length_q  <= body_length_d;
      type_word_q    <= type_word_d;
      name_length_q  <= name_length_d;
      text_length_q  <= text_length_d;
      bytes_left_q   <= bytes_left_d;
    end
  end

  // Prefix counter never runs past the last prefix byte
  a_prefix_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == lpfp_pkg::PhPrefix) |-> (header_index_q <= lpfp_pkg::PrefixLastIdx))
    else $error("prefix byte counter out of range");

  // Name and text phases always have bytes outstanding
  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == lpfp_pkg::PhName || phase_q == lpfp_pkg::PhText) |-> (bytes_left_q != 32'd0))
    else $error("payload phase with no bytes left");

  // An error restarts the parser at the prefix
  a_error_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (result_o.status == lpfp_pkg::StRange ||
                result_o.status == lpfp_pkg::StMismatch))
    |=> (phase_q == lpfp_pkg::PhPrefix && header_index_q == 4'd0 && body_length_q == 32'd0))
    else $error("parser did not restart after error");

  // Frame end only on a good beat, followed by a clean prefix
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && result_o.frame_end)
    |=> (phase_q == lpfp_pkg::PhPrefix && type_word_q == 32'd0 && bytes_left_q == 32'd0))
    else $error("frame end did not restart the parser");

endmodule

// File: rtl/length_prefixed_frame_parser.sv
`timescale 1ns / 1ps

// Length-prefixed frame parser.
// Input channel: one raw stream byte per beat on data_byte_i (in_valid_i /
// in_ready_o). Output channel: one result beat per input beat with status,
// payload byte, frame end flag and message type (out_valid_o / out_ready_i).
// Config channel: cfg_valid_i / cfg_ready_o writes max_body_len from
// cfg_data_i; it is always ready and is meant to be written while idle.
// The result of an accepted byte is registered and appears in the next cycle.
// Throughput: one byte per cycle unless a result stalls; the frame state
// update and length checks are combinational ahead of the result register.
// Stall: while a result waits and out_ready_i is low, in_ready_o drops, so
// the result register holds and no byte is lost. in_ready_o follows
// out_ready_i combinationally when a result is pending.
// Reset: the parser starts at a length prefix with all frame state cleared,
// no result pending, and max_body_len at 32 MiB.
module length_prefixed_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  payload_byte_o,
  output logic        frame_end_o,
  output logic [31:0] message_type_o
);

  logic [31:0]       max_body_len_q;
  logic              out_valid_q;
  lpfp_pkg::result_t result_q;
  lpfp_pkg::result_t step_result;
  logic              in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;

  // Hold the length cap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_len_q <= lpfp_pkg::DefaultMaxBody;
    end else if (cfg_valid_i) begin
      max_body_len_q <= cfg_data_i;
    end
  end

  lpfp_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_accept),
    .data_byte_i    (data_byte_i),
    .max_body_len_i (max_body_len_q),
    .result_o       (step_result)
  );

  // Result register: load on accept, clear valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= step_result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = result_q.status;
  assign payload_byte_o = result_q.payload_byte;
  assign frame_end_o    = result_q.frame_end;
  assign message_type_o = result_q.message_type;

  // A stalled result is never overwritten by a new beat
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_accept)
    else $error("result overwritten while stalled");

  // Every accepted beat shows up as a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted beat produced no result");

  // A stalled result holds its contents
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(result_q))
    else $error("stalled result changed");

endmodule

// File: tb/sv/length_prefixed_frame_parser_tb.sv
`timescale 1ns / 1ps

module length_prefixed_frame_parser_tb;

  localparam int StallLimit = 2000;
  localparam int PhaseBytes = 150;

  typedef struct {
    logic [7:0]        data;
    bit                pinned;
    lpfp_pkg::result_t want;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  payload_byte_o;
  logic        frame_end_o;
  logic [31:0] message_type_o;

  // Parser state as predicted from the beats accepted so far
  logic [1:0]  pr_phase = lpfp_pkg::PhPrefix;
  logic [3:0]  pr_index = '0;
  logic [31:0] pr_body = '0;
  logic [31:0] pr_type = '0;
  logic [31:0] pr_name_bytes = '0;
  logic [31:0] pr_text_bytes = '0;
  logic [31:0] pr_left = '0;
  logic [31:0] cap_bytes = lpfp_pkg::DefaultMaxBody;

  lpfp_pkg::result_t results_due[$];
  directed_row_t     directed_rows[$];
  bit                pin_want = 1'b0;
  lpfp_pkg::result_t pinned_result = '0;
  int                fail_count = 0;
  int                sent_count = 0;
  int                results_seen = 0;

  length_prefixed_frame_parser u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .payload_byte_o (payload_byte_o),
    .frame_end_o    (frame_end_o),
    .message_type_o (message_type_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_frame();
    pr_phase      = lpfp_pkg::PhPrefix;
    pr_index      = '0;
    pr_body       = '0;
    pr_type       = '0;
    pr_name_bytes = '0;
    pr_text_bytes = '0;
    pr_left       = '0;
  endfunction

  // Advance the predicted parser by one byte and return the result it gives
  function automatic lpfp_pkg::result_t parse_byte(input logic [7:0] b);
    lpfp_pkg::result_t r;
    logic [33:0]       sum;
    r = '0;
    r.status = lpfp_pkg::StHdr;
    case (pr_phase)
      lpfp_pkg::PhPrefix: begin
        pr_body = {pr_body[23:0], b};
        if (pr_index >= lpfp_pkg::PrefixLastIdx) begin
          if (pr_body < lpfp_pkg::HeaderBytes || pr_body > cap_bytes) begin
            r.status = lpfp_pkg::StRange;
            clear_frame();
          end else begin
            pr_phase = lpfp_pkg::PhHeader;
            pr_index = '0;
          end
        end else begin
          pr_index = pr_index + 4'd1;
        end
      end
      lpfp_pkg::PhHeader: begin
        if (pr_index < lpfp_pkg::TypeEndIdx) pr_type = {pr_type[23:0], b};
        else if (pr_index < lpfp_pkg::NameEndIdx) pr_name_bytes = {pr_name_bytes[23:0], b};
        else pr_text_bytes = {pr_text_bytes[23:0], b};
        if (pr_index >= lpfp_pkg::HeaderLastIdx) begin
          // full-width sum: a wrapped total must not pass as a match
          sum = 34'(lpfp_pkg::HeaderBytes) + 34'(pr_name_bytes) + 34'(pr_text_bytes);
          if (sum != 34'(pr_body)) begin
            r.status = lpfp_pkg::StMismatch;
            clear_frame();
          end else if (pr_name_bytes != 0) begin
            pr_phase = lpfp_pkg::PhName;
            pr_left  = pr_name_bytes;
          end else if (pr_text_bytes != 0) begin
            pr_phase = lpfp_pkg::PhText;
            pr_left  = pr_text_bytes;
          end else begin
            r.frame_end    = 1'b1;
            r.message_type = pr_type;
            clear_frame();
          end
        end else begin
          pr_index = pr_index + 4'd1;
        end
      end
      lpfp_pkg::PhName: begin
        r.status       = lpfp_pkg::StName;
        r.payload_byte = b;
        pr_left        = pr_left - 32'd1;
        if (pr_left == 0) begin
          if (pr_text_bytes != 0) begin
            pr_phase = lpfp_pkg::PhText;
            pr_left  = pr_text_bytes;
          end else begin
            r.frame_end    = 1'b1;
            r.message_type = pr_type;
            clear_frame();
          end
        end
      end
      default: begin
        r.status       = lpfp_pkg::StText;
        r.payload_byte = b;
        pr_left        = pr_left - 32'd1;
        if (pr_left == 0) begin
          r.frame_end    = 1'b1;
          r.message_type = pr_type;
          clear_frame();
        end
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Check result beats in order and queue a prediction for each accepted byte
  always @(posedge clk_i) begin
    lpfp_pkg::result_t got;
    lpfp_pkg::result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {status_o, payload_byte_o, frame_end_o, message_type_o};
        results_seen++;
        if (results_due.size() == 0) begin
          flag_mismatch("result beat with nothing pending");
        end else begin
          want = results_due.pop_front();
          if (got.status != want.status)
            flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.payload_byte != want.payload_byte)
            flag_mismatch($sformatf("payload 0x%02h, want 0x%02h",
                                    got.payload_byte, want.payload_byte));
          if (got.frame_end != want.frame_end)
            flag_mismatch($sformatf("frame_end %0b, want %0b", got.frame_end,
                                    want.frame_end));
          if (got.message_type != want.message_type)
            flag_mismatch($sformatf("message_type 0x%08h, want 0x%08h",
                                    got.message_type, want.message_type));
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = parse_byte(data_byte_i);
        if (pin_want) want = pinned_result;
        results_due.push_back(want);
      end
    end
  end

  // Drop out_ready at random, hold it low once for a long stretch, and keep
  // it high through a quiet window
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 300) begin
        held      = 1'b1;
        hold_left = 60;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (results_seen >= 480 && results_seen < 720) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 7);
      end
    end
  end

  // End the run when no beat moves on any channel for too long
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  // Offer one byte, idling at random first; return at the falling edge after
  // the beat is taken
  task automatic send_byte(input logic [7:0] b);
    bit quiet;
    quiet = (sent_count >= 500 && sent_count < 700);
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_cap(input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_bytes = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void push_word(ref logic [7:0] q[$], input logic [31:0] w);
    q.push_back(w[31:24]);
    q.push_back(w[23:16]);
    q.push_back(w[15:8]);
    q.push_back(w[7:0]);
  endfunction

  function automatic logic [31:0] pick_len();
    return ($urandom_range(9) < 7) ? 32'($urandom_range(4)) : 32'($urandom_range(24));
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit pinned,
                                  input lpfp_pkg::result_t want);
    directed_row_t row;
    row.data   = b;
    row.pinned = pinned;
    row.want   = want;
    directed_rows.push_back(row);
  endfunction

  // Send one frame, broken frame or noise burst, then feed bytes until the
  // parser is back at a length prefix
  task automatic send_unit();
    logic [7:0]  frame_q[$];
    logic [31:0] body;
    logic [31:0] nm_bytes;
    logic [31:0] tx_bytes;
    int          kind;
    int          cut;
    int          spins;
    kind     = $urandom_range(99);
    nm_bytes = pick_len();
    tx_bytes = pick_len();
    body     = lpfp_pkg::HeaderBytes + nm_bytes + tx_bytes;
    if (kind < 70 && kind >= 60) begin
      // length prefix outside the accepted range
      if (cap_bytes != 32'hFFFF_FFFF && $urandom_range(1))
        body = $urandom_range(32'hFFFF_FFFF, cap_bytes + 32'd1);
      else
        body = $urandom_range(11);
      push_word(frame_q, body);
    end else if (kind >= 70 && kind < 80) begin
      // header lengths that do not add up, sometimes only after a wrap
      if ($urandom_range(2) == 0) begin
        if ($urandom_range(1)) begin
          nm_bytes = 32'hFFFF_FFFF;
          tx_bytes = body - 32'd11;
        end else begin
          tx_bytes = 32'hFFFF_FFFF;
          nm_bytes = body - 32'd11;
        end
      end else if ($urandom_range(1)) begin
        body = body + 32'd1;
      end else begin
        tx_bytes = tx_bytes + 32'd1;
      end
      push_word(frame_q, body);
      push_word(frame_q, $urandom());
      push_word(frame_q, nm_bytes);
      push_word(frame_q, tx_bytes);
    end else if (kind < 90) begin
      push_word(frame_q, body);
      push_word(frame_q, $urandom());
      push_word(frame_q, nm_bytes);
      push_word(frame_q, tx_bytes);
      repeat (nm_bytes + tx_bytes) frame_q.push_back(8'($urandom_range(255)));
      if (kind >= 80) begin
        // truncate the frame somewhere
        cut = $urandom_range(frame_q.size() - 1, 1);
        frame_q = frame_q[0:cut-1];
      end
    end else begin
      repeat ($urandom_range(8, 1)) frame_q.push_back(8'($urandom_range(255)));
    end

    // Abandon the rest once the parser has restarted on an error
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i]);
      if (kind < 90 && i != frame_q.size() - 1 &&
          pr_phase == lpfp_pkg::PhPrefix && pr_index == 0) break;
    end

    spins = 0;
    while (!(pr_phase == lpfp_pkg::PhPrefix && pr_index == 0) && spins < 64) begin
      send_byte(8'($urandom_range(255)));
      spins++;
    end
  endtask

  // Main sequence: reset, directed rows, then random phases at several caps
  initial begin
    logic [31:0] cap_plan[7];
    int          phase_start;
    cap_plan = '{lpfp_pkg::DefaultMaxBody, 32'd12, 32'hFFFF_FFFF, 32'd11, 32'd0, 32'd0,
                 lpfp_pkg::DefaultMaxBody};

    // body length below the header size
    add_row(8'h00, 1'b1, '0);
    add_row(8'h00, 1'b1, '0);
    add_row(8'h00, 1'b1, '0);
    add_row(8'h0B, 1'b1, {lpfp_pkg::StRange, 8'h00, 1'b0, 32'h0});
    // body length of all ones, above the reset cap
    add_row(8'hFF, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'hFF, 1'b0, '0);
    add_row(8'hFF, 1'b1, {lpfp_pkg::StRange, 8'h00, 1'b0, 32'h0});
    // empty body with an all-ones type
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h0C, 1'b0, '0);
    repeat (4) add_row(8'hFF, 1'b0, '0);
    repeat (7) add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b1, {lpfp_pkg::StHdr, 8'h00, 1'b1, 32'hFFFF_FFFF});

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      pin_want      = directed_rows[i].pinned;
      pinned_result = directed_rows[i].want;
      send_byte(directed_rows[i].data);
    end
    pin_want = 1'b0;

    for (int p = 0; p < 7; p++) begin
      if (p != 0) begin
        drain_results();
        write_cap(p == 5 ? 32'($urandom_range(300, 40)) : cap_plan[p]);
      end
      phase_start = sent_count;
      while (sent_count - phase_start < PhaseBytes) send_unit();
    end

    drain_results();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: length_prefixed_frame_parser.f
rtl/lpfp_pkg.sv
rtl/lpfp_parse.sv
rtl/length_prefixed_frame_parser.sv
tb/sv/length_prefixed_frame_parser_tb.sv
